FILE: src/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
`define AST_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition");
`else
`define AST_PROP(label, clk, rst, prop)
`define AST_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: src/bac_pkg.sv
package bac_pkg;
   localparam int ADDR_W = 48;
   localparam int UO_W = 5;
   localparam int PO_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int DEFAULT_LOG_UNITS = 10;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UNIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POOL = 2'd2;

   localparam logic [ADDR_W-1:0] RESET_BASE = '0;
   localparam logic [UO_W-1:0] RESET_UNIT = 5'd8;
   localparam logic [PO_W-1:0] RESET_POOL = 6'd18;

   typedef struct packed {
      logic cmd;
      logic [ADDR_W-1:0] request_bytes;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic ok;
      logic [ADDR_W-1:0] region_address;
   } rsp_type;
endpackage

FILE: src/bac_ram.sv
module bac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/buddy_allocator_core.sv
// buddy allocator over a pool of 2^R units, R = pool order - unit order (0..LOG_UNITS)
// command channel: drive req_data and raise start while busy is low; the item is
// taken on that edge. exactly one result follows on rsp_data, flagged by rsp_strobe
// for a single cycle, unless a csr write drops the item first; the receiver cannot
// stall it, so it must take it then.
// allocate: round the request up to units and size it to level k (fail if oversized),
// then scan the free-mark memory, one read per cycle at stride 2^k, 2^(R-k) reads at
// most, stopping early once a block of level k is found; take it, split a level at a time.
// free: find the unit (fail if outside the pool or not allocated), then merge with the
// buddy while it is free at the current level, and set the free mark of the merged block.
// the result is strobed the cycle after the last step; busy drops in that same cycle,
// so the next item can be taken while the result is strobed.
// both paths share one read and one write port on each table memory.
// reset, and any write to a known csr index, restore the reset config (reset only)
// and start a clearing pass over all 2^LOG_UNITS entries (1024 by default) of both
// memories; busy is high during it and csr writes are still taken, restarting it.
// csr port: csr_write_en, csr_index (0 base, 1 unit order, 2 pool order), csr_wdata.
module buddy_allocator_core #(
   parameter int LOG_UNITS = bac_pkg::DEFAULT_LOG_UNITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  bac_pkg::req_type req_data,
   output logic rsp_strobe,
   output bac_pkg::rsp_type rsp_data,
   input  logic csr_write_en,
   input  logic [bac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bac_pkg::ADDR_W-1:0] csr_wdata
);
   import bac_pkg::*;
   `include "assert_macros.svh"

   localparam int LW = $clog2(LOG_UNITS + 1);
   localparam int MW = LOG_UNITS + 1;
   localparam int TW = LW + 1;
   localparam int NU = 1 << LOG_UNITS;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_A_ROUND = 4'd2;
   localparam logic [3:0] S_A_LEVEL = 4'd3;
   localparam logic [3:0] S_A_SCAN = 4'd4;
   localparam logic [3:0] S_A_TAKE = 4'd5;
   localparam logic [3:0] S_A_SPLIT = 4'd6;
   localparam logic [3:0] S_F_OFFS = 4'd7;
   localparam logic [3:0] S_F_UNIT = 4'd8;
   localparam logic [3:0] S_F_LOOK = 4'd9;
   localparam logic [3:0] S_F_MERGE = 4'd10;
   localparam logic [3:0] S_F_MCHK = 4'd11;
   localparam logic [3:0] S_F_PLACE = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [UO_W-1:0] uo_ff, uo_in;
   logic [PO_W-1:0] po_ff, po_in;
   logic [LOG_UNITS-1:0] cnt_ff, cnt_in;
   req_type req_ff, req_in;
   logic [ADDR_W:0] units_ff, units_in;
   logic [LW-1:0] k_ff, k_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [MW-1:0] scan_ff, scan_in;
   logic pend_ff, pend_in;
   logic [LOG_UNITS-1:0] pidx_ff, pidx_in;
   logic found_ff, found_in;
   logic [LW-1:0] best_lvl_ff, best_lvl_in;
   logic [LOG_UNITS-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [LW-1:0] top;
   logic [PO_W:0] diff;
   logic [ADDR_W-1:0] umask;
   logic [MW-1:0] top_span;
   logic issue;
   logic [MW-1:0] masked;
   logic hit;
   logic [LW-1:0] hit_lvl;
   logic [ADDR_W-1:0] unit_no;
   logic [LOG_UNITS-1:0] buddy;
   logic csr_hit;
   logic fin, fin_ok;
   logic [ADDR_W-1:0] fin_addr;

   logic marks_we;
   logic [LOG_UNITS-1:0] marks_waddr, marks_raddr;
   logic [MW-1:0] marks_wdata, marks_rdata;
   logic tab_we;
   logic [LOG_UNITS-1:0] tab_waddr, tab_raddr;
   logic [TW-1:0] tab_wdata, tab_rdata;

   bac_ram #(.WIDTH(MW), .DEPTH(NU)) u_marks (
      .clock(clock), .wr_en(marks_we), .wr_addr(marks_waddr), .wr_data(marks_wdata),
      .rd_addr(marks_raddr), .rd_data(marks_rdata)
   );

   bac_ram #(.WIDTH(TW), .DEPTH(NU)) u_table (
      .clock(clock), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
      .rd_addr(tab_raddr), .rd_data(tab_rdata)
   );

   always_comb begin
      diff = {1'b0, po_ff} - {2'b00, uo_ff};
      if (po_ff <= {1'b0, uo_ff}) begin
         top = '0;
      end else if (diff > (PO_W+1)'(LOG_UNITS)) begin
         top = LW'(LOG_UNITS);
      end else begin
         top = diff[LW-1:0];
      end
      umask = (ADDR_W'(1) << uo_ff) - ADDR_W'(1);
      top_span = MW'(1) << top;
      unit_no = off_ff >> uo_ff;
      buddy = idx_ff ^ (LOG_UNITS'(1) << lvl_ff);
      masked = marks_rdata & ~((MW'(1) << k_ff) - MW'(1));
      hit = (masked != '0);
      hit_lvl = '0;
      for (int i = MW - 1; i >= 0; i--) begin
         if (masked[i]) begin
            hit_lvl = LW'(i);
         end
      end
      issue = (scan_ff < top_span) && !(found_ff && (best_lvl_ff == k_ff));
      csr_hit = csr_write_en && (csr_index inside {REG_BASE, REG_UNIT, REG_POOL});
   end

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      uo_in = uo_ff;
      po_in = po_ff;
      cnt_in = cnt_ff;
      req_in = req_ff;
      units_in = units_ff;
      k_in = k_ff;
      lvl_in = lvl_ff;
      scan_in = scan_ff;
      pend_in = 1'b0;
      pidx_in = pidx_ff;
      found_in = found_ff;
      best_lvl_in = best_lvl_ff;
      idx_in = idx_ff;
      off_in = off_ff;
      fin = 1'b0;
      fin_ok = 1'b0;
      fin_addr = '0;
      marks_we = 1'b0;
      marks_waddr = idx_ff;
      marks_wdata = '0;
      marks_raddr = scan_ff[LOG_UNITS-1:0];
      tab_we = 1'b0;
      tab_waddr = idx_ff;
      tab_wdata = '0;
      tab_raddr = unit_no[LOG_UNITS-1:0];

      case (state_ff)
         S_CLEAR: begin
            marks_we = 1'b1;
            marks_waddr = cnt_ff;
            marks_wdata = (cnt_ff == '0) ? top_span : '0;
            tab_we = 1'b1;
            tab_waddr = cnt_ff;
            cnt_in = cnt_ff + LOG_UNITS'(1);
            if (cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = (req_data.cmd == CMD_FREE) ? S_F_OFFS : S_A_ROUND;
            end
         end
         S_A_ROUND: begin
            units_in = ({1'b0, req_ff.request_bytes} + {1'b0, umask}) >> uo_ff;
            k_in = '0;
            state_in = S_A_LEVEL;
         end
         S_A_LEVEL: begin
            if (units_ff <= ((ADDR_W+1)'(1) << k_ff)) begin
               scan_in = '0;
               found_in = 1'b0;
               state_in = S_A_SCAN;
            end else if (k_ff >= top) begin
               fin = 1'b1;
            end else begin
               k_in = k_ff + LW'(1);
            end
         end
         S_A_SCAN: begin
            if (pend_ff && hit && (!found_ff || hit_lvl < best_lvl_ff)) begin
               found_in = 1'b1;
               best_lvl_in = hit_lvl;
               idx_in = pidx_ff;
            end
            if (issue) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[LOG_UNITS-1:0];
               scan_in = scan_ff + (MW'(1) << k_ff);
            end else if (!pend_ff) begin
               if (found_ff) begin
                  state_in = S_A_TAKE;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         S_A_TAKE: begin
            marks_we = 1'b1;
            tab_we = 1'b1;
            tab_wdata = {1'b1, k_ff};
            lvl_in = best_lvl_ff;
            state_in = S_A_SPLIT;
         end
         S_A_SPLIT: begin
            if (lvl_ff > k_ff) begin
               marks_we = 1'b1;
               marks_waddr = idx_ff + (LOG_UNITS'(1) << (lvl_ff - LW'(1)));
               marks_wdata = MW'(1) << (lvl_ff - LW'(1));
               lvl_in = lvl_ff - LW'(1);
            end else begin
               fin = 1'b1;
               fin_ok = 1'b1;
               fin_addr = base_ff + (ADDR_W'(idx_ff) << uo_ff);
            end
         end
         S_F_OFFS: begin
            off_in = (req_ff.free_address & ~umask) - base_ff;
            state_in = S_F_UNIT;
         end
         S_F_UNIT: begin
            if ((unit_no >> top) != '0) begin
               fin = 1'b1;
            end else begin
               idx_in = unit_no[LOG_UNITS-1:0];
               state_in = S_F_LOOK;
            end
         end
         S_F_LOOK: begin
            if (!tab_rdata[TW-1]) begin
               fin = 1'b1;
            end else begin
               tab_we = 1'b1;
               lvl_in = tab_rdata[LW-1:0];
               state_in = S_F_MERGE;
            end
         end
         S_F_MERGE: begin
            if (lvl_ff < top) begin
               marks_raddr = buddy;
               state_in = S_F_MCHK;
            end else begin
               state_in = S_F_PLACE;
            end
         end
         S_F_MCHK: begin
            if (marks_rdata[lvl_ff]) begin
               marks_we = 1'b1;
               marks_waddr = buddy;
               idx_in = idx_ff & ~(LOG_UNITS'(1) << lvl_ff);
               lvl_in = lvl_ff + LW'(1);
               state_in = S_F_MERGE;
            end else begin
               state_in = S_F_PLACE;
            end
         end
         S_F_PLACE: begin
            marks_we = 1'b1;
            marks_wdata = MW'(1) << lvl_ff;
            fin = 1'b1;
            fin_ok = 1'b1;
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in = '0;
         end
      endcase

      if (fin) begin
         state_in = S_IDLE;
      end
      rsp_valid_in = fin && !csr_hit;
      rsp_in.ok = fin_ok;
      rsp_in.region_address = fin_addr;

      if (csr_hit) begin
         case (csr_index)
            REG_BASE: base_in = csr_wdata;
            REG_UNIT: uo_in = csr_wdata[UO_W-1:0];
            REG_POOL: po_in = csr_wdata[PO_W-1:0];
            default: base_in = base_ff;
         endcase
         state_in = S_CLEAR;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         base_ff <= RESET_BASE;
         uo_ff <= RESET_UNIT;
         po_ff <= RESET_POOL;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         base_ff <= base_in;
         uo_ff <= uo_in;
         po_ff <= po_in;
         pend_ff <= pend_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      units_ff <= units_in;
      k_ff <= k_in;
      lvl_ff <= lvl_in;
      scan_ff <= scan_in;
      pidx_ff <= pidx_in;
      best_lvl_ff <= best_lvl_in;
      idx_ff <= idx_in;
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `AST_PROP(a_strobe_single, clock, reset, rsp_valid_ff |=> !rsp_valid_ff)
   `AST_PROP(a_accept_busy, clock, reset, (start && !busy && !csr_write_en) |=> busy)
   `AST_NEVER(a_fail_zero, clock, reset, rsp_valid_ff && !rsp_ff.ok && rsp_ff.region_address != '0)
   `AST_NEVER(a_strobe_busy, clock, reset, rsp_valid_ff && busy)
endmodule

FILE: tb/sv/tb_buddy_allocator_core.sv
module tb_buddy_allocator_core;
   import bac_pkg::*;

   localparam int LOG_UNITS = DEFAULT_LOG_UNITS;
   localparam int NUM_UNITS = 1 << LOG_UNITS;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0] csr_wdata = '0;

   buddy_allocator_core #(.LOG_UNITS(LOG_UNITS)) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // allocator state mirror
   logic [ADDR_W-1:0] pool_base;
   logic [UO_W-1:0] unit_log2;
   logic [PO_W-1:0] pool_shift;
   logic [LOG_UNITS:0] free_mask [NUM_UNITS];
   logic owned [NUM_UNITS];
   logic [4:0] owned_level [NUM_UNITS];

   req_type pending_items [$];
   rsp_type expected_rsps [$];
   logic [ADDR_W-1:0] live_regions [$];
   int sender_idle_pct = 0;
   int error_count = 0;
   logic took_item = 1'b0;

   function automatic int pool_levels();
      if (pool_shift <= unit_log2) return 0;
      if (pool_shift - unit_log2 > LOG_UNITS) return LOG_UNITS;
      return pool_shift - unit_log2;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < NUM_UNITS; i++) begin
         free_mask[i] = '0;
         owned[i] = 1'b0;
         owned_level[i] = '0;
      end
      free_mask[0][pool_levels()] = 1'b1;
      live_regions.delete();
   endfunction

   function automatic rsp_type allocate_region(logic [ADDR_W-1:0] bytes);
      rsp_type r;
      int top;
      int k;
      logic [63:0] units;
      r = '0;
      top = pool_levels();
      units = ({16'd0, bytes} + ((64'd1 << unit_log2) - 1)) >> unit_log2;
      if (units == 0) units = 1;
      k = 0;
      while (k < 63 && (64'd1 << k) < units) k++;
      if (k > top) return r;
      for (int lvl = k; lvl <= top; lvl++) begin
         for (int idx = 0; idx < (1 << top); idx += (1 << lvl)) begin
            if (free_mask[idx][lvl]) begin
               free_mask[idx][lvl] = 1'b0;
               owned[idx] = 1'b1;
               owned_level[idx] = 5'(k);
               for (int c = lvl; c > k; c--) free_mask[idx + (1 << (c - 1))][c - 1] = 1'b1;
               r.ok = 1'b1;
               r.region_address = pool_base + (ADDR_W'(idx) << unit_log2);
               return r;
            end
         end
      end
      return r;
   endfunction

   function automatic rsp_type release_region(logic [ADDR_W-1:0] addr);
      rsp_type r;
      int top;
      int idx;
      int lvl;
      int buddy;
      logic [ADDR_W-1:0] offs;
      logic [ADDR_W-1:0] u;
      r = '0;
      top = pool_levels();
      offs = (addr & ~((ADDR_W'(1) << unit_log2) - 1)) - pool_base;
      u = offs >> unit_log2;
      if (u >= (ADDR_W'(1) << top)) return r;
      idx = int'(u);
      if (!owned[idx]) return r;
      owned[idx] = 1'b0;
      lvl = owned_level[idx];
      owned_level[idx] = '0;
      while (lvl < top) begin
         buddy = idx ^ (1 << lvl);
         if (!free_mask[buddy][lvl]) break;
         free_mask[buddy][lvl] = 1'b0;
         if (buddy < idx) idx = buddy;
         lvl++;
      end
      free_mask[idx][lvl] = 1'b1;
      r.ok = 1'b1;
      return r;
   endfunction

   always @(negedge clock) begin
      if (!start || took_item) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data <= pending_items.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      took_item <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result ok=%0b addr=%h", rsp_data.ok, rsp_data.region_address);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.ok !== want.ok) begin
                  $error("ok: expected %0b actual %0b", want.ok, rsp_data.ok);
                  error_count++;
               end
               if (rsp_data.region_address !== want.region_address) begin
                  $error("region_address: expected %h actual %h",
                         want.region_address, rsp_data.region_address);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_data.cmd == CMD_ALLOC) begin
               want = allocate_region(req_data.request_bytes);
               if (want.ok) live_regions.insert(live_regions.size(), want.region_address);
            end else begin
               want = release_region(req_data.free_address);
            end
            expected_rsps.insert(expected_rsps.size(), want);
         end
      end
   end

   task automatic push_item(logic cmd, logic [ADDR_W-1:0] bytes, logic [ADDR_W-1:0] addr);
      req_type it;
      it.cmd = cmd;
      it.request_bytes = bytes;
      it.free_address = addr;
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_rsps.size() > 0 || start) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      csr_wdata <= ADDR_W'({$urandom, $urandom});
      case (idx)
         REG_BASE: pool_base = value;
         REG_UNIT: unit_log2 = value[UO_W-1:0];
         REG_POOL: pool_shift = value[PO_W-1:0];
         default: ;
      endcase
      if (idx == REG_BASE || idx == REG_UNIT || idx == REG_POOL) clear_pool();
   endtask

   task automatic set_layout(logic [ADDR_W-1:0] b, logic [UO_W-1:0] uo, logic [PO_W-1:0] po);
      csr_write(REG_BASE, b);
      csr_write(REG_UNIT, ADDR_W'(uo));
      csr_write(REG_POOL, ADDR_W'(po));
   endtask

   task automatic random_batch(int n);
      int top;
      int lvl;
      int pick;
      logic [63:0] span;
      logic [ADDR_W-1:0] bytes;
      logic [ADDR_W-1:0] addr;
      for (int i = 0; i < n; i++) begin
         top = pool_levels();
         bytes = ADDR_W'({$urandom, $urandom});
         addr = ADDR_W'({$urandom, $urandom});
         if ($urandom_range(99) < 55 || live_regions.size() == 0) begin
            lvl = $urandom_range(0, top + 1);
            span = 64'd1 << (unit_log2 + lvl);
            pick = $urandom_range(99);
            if (pick < 4) bytes = '0;
            else if (pick < 14) bytes = ADDR_W'({$urandom, $urandom});
            else bytes = ADDR_W'(({$urandom, $urandom} % span) + 1);
            push_item(CMD_ALLOC, bytes, addr);
         end else begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               int j;
               j = $urandom_range(0, live_regions.size() - 1);
               addr = live_regions[j];
               live_regions.delete(j);
               if ($urandom_range(1)) begin
                  addr = addr + (ADDR_W'({$urandom, $urandom})
                                 & ((ADDR_W'(1) << unit_log2) - 1));
               end
            end else if (pick < 90) begin
               addr = pool_base + (ADDR_W'($urandom_range(0, (1 << top) + 1)) << unit_log2);
            end
            push_item(CMD_FREE, bytes, addr);
         end
      end
   endtask

   initial begin
      int phase;
      pool_base = RESET_BASE;
      unit_log2 = RESET_UNIT;
      pool_shift = RESET_POOL;
      clear_pool();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default layout: zero size, oversized, whole pool, unknown and repeated free
      push_item(CMD_ALLOC, '0, ADDR_MAX);
      push_item(CMD_ALLOC, ADDR_MAX, '0);
      push_item(CMD_ALLOC, 48'h4_0000, '0);
      push_item(CMD_ALLOC, 48'h101, '0);
      push_item(CMD_FREE, '0, '0);
      push_item(CMD_FREE, '0, 48'h1_00ff);
      push_item(CMD_FREE, '0, 48'h4_0000);
      push_item(CMD_FREE, ADDR_MAX, ADDR_MAX);
      push_item(CMD_FREE, '0, 48'h200);
      push_item(CMD_FREE, '0, 48'h200);
      push_item(CMD_ALLOC, 48'h4_0000, '0);
      push_item(CMD_FREE, '0, '0);
      // small pool run to exhaustion, wrapped base
      set_layout(ADDR_MAX - 48'h1f, 5'd4, 6'd7);
      csr_write(REG_UNUSED, ADDR_MAX);
      for (int i = 0; i < 9; i++) push_item(CMD_ALLOC, 48'(i), '0);
      push_item(CMD_FREE, '0, 48'h10);
      push_item(CMD_ALLOC, 48'h10, '0);
      drain();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_layout(48'h1000, 5'd8, 6'd18);
            1: set_layout(48'hffff_ffff_f000, 5'd4, 6'd10);
            2: set_layout(ADDR_W'({$urandom, $urandom}), 5'd0, 6'd34);
            3: set_layout('0, 5'd24, 6'd0);
            4: set_layout(ADDR_MAX, 5'd24, 6'd34);
            default: set_layout(ADDR_W'({$urandom, $urandom}), 5'd3, 6'd9);
         endcase
         sender_idle_pct = (phase < 2) ? 17 : (phase < 4) ? 62 : 0;
         for (int b = 0; b < 33; b++) begin
            random_batch(4);
            while (pending_items.size() > 0) @(negedge clock);
         end
         drain();
      end
      sender_idle_pct = 0;

      drain();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(64'd400_000_000);
      $display("Regression FAIL");
      $finish;
   end
endmodule
